// ----- rtl/core/pcdk_pkg.sv -----
// Shared types, port codes and field widths for the display and keyboard port block.
package pcdk_pkg;

   // field widths
   localparam int PORT_W      = 16;
   localparam int BYTE_W      = 8;
   localparam int ACTION_W    = 2;
   localparam int COLOR_W     = 24;
   localparam int COL_W       = 7;
   localparam int ROW_W       = 5;
   localparam int START_W     = 6;
   localparam int END_W       = 5;
   localparam int MODE_W      = 2;
   localparam int HIGH_W      = 3;
   localparam int POS_W       = HIGH_W + BYTE_W;
   localparam int CHAN_W      = 6;

   // stream payload widths
   localparam int REQ_TDATA_W = 32;
   localparam int REQ_TUSER_W = ACTION_W;
   localparam int RSP_TDATA_W = 72;
   localparam int RSP_TUSER_W = 1;

   // sizes
   localparam int PORT_RANGE       = 65536;
   localparam int PORT_SPACE_MIN   = 1024;
   localparam int PORT_SPACE_DEF   = 65536;
   localparam int TEXT_COLUMNS_DEF = 80;
   localparam int PALETTE_DEPTH    = 256;
   localparam int PAL_AW           = $clog2(PALETTE_DEPTH);
   localparam int QUEUE_DEPTH      = 2;
   // quotient of port by echo store size, wide enough for the smallest store
   localparam int ECHO_QW          = $clog2(PORT_RANGE / PORT_SPACE_MIN + 1);

   // port numbers
   localparam logic [PORT_W-1:0] PORT_PIC_CMD    = 16'h0020;
   localparam logic [PORT_W-1:0] PORT_KBD_DATA   = 16'h0060;
   localparam logic [PORT_W-1:0] PORT_KBD_STAT   = 16'h0064;
   localparam logic [PORT_W-1:0] PORT_DAC_INDEX  = 16'h03C8;
   localparam logic [PORT_W-1:0] PORT_DAC_DATA   = 16'h03C9;
   localparam logic [PORT_W-1:0] PORT_CRTC_INDEX = 16'h03D4;
   localparam logic [PORT_W-1:0] PORT_CRTC_DATA  = 16'h03D5;
   localparam logic [PORT_W-1:0] PORT_MODE       = 16'h03D8;

   // CRTC register indexes
   localparam logic [BYTE_W-1:0] CRTC_CUR_START = 8'h0A;
   localparam logic [BYTE_W-1:0] CRTC_CUR_END   = 8'h0B;
   localparam logic [BYTE_W-1:0] CRTC_CUR_HIGH  = 8'h0E;
   localparam logic [BYTE_W-1:0] CRTC_CUR_LOW   = 8'h0F;

   localparam logic [START_W-1:0] CUR_START_RST = 6'd14;
   localparam logic [END_W-1:0]   CUR_END_RST   = 5'd15;
   localparam int                 EOI_BIT       = 5;

   typedef enum logic [ACTION_W-1:0] {
      ACT_READ,
      ACT_WRITE,
      ACT_KEY,
      ACT_LOOKUP
   } action_type;

   typedef enum logic [3:0] {
      PCL_OTHER,
      PCL_EOI,
      PCL_KEY_DATA,
      PCL_KEY_STAT,
      PCL_DAC_INDEX,
      PCL_DAC_DATA,
      PCL_CRTC_INDEX,
      PCL_CRTC_DATA,
      PCL_MODE
   } port_class_type;

   typedef struct packed {
      action_type           action;
      port_class_type       pclass;
      logic [PORT_W-1:0]    port;
      logic [ECHO_QW-1:0]   echo_q;
      logic [BYTE_W-1:0]    data;
      logic [BYTE_W-1:0]    kstat;
   } item_type;

endpackage

// ----- rtl/core/pcdk_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module pcdk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/pcdk_front.sv -----
// Front end: accepts request items, classifies the port and reduces it for the echo store.
module pcdk_front #(
   parameter int PORT_SPACE = pcdk_pkg::PORT_SPACE_DEF
) (
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [pcdk_pkg::REQ_TDATA_W-1:0] req_tdata,  // port[15:0], data[23:16], key_status[31:24]
   input  logic [pcdk_pkg::REQ_TUSER_W-1:0] req_tuser,  // action[1:0]
   input  logic                             clearing,
   input  logic                             q_full,
   output logic                             q_push,
   output pcdk_pkg::item_type               q_item
);
   import pcdk_pkg::*;

   // port / PORT_SPACE by reciprocal multiply, exact for any 16-bit port
   localparam int              ECHO_SHIFT = PORT_W + $clog2(PORT_SPACE);
   localparam longint unsigned ECHO_RECIP =
      ((64'd1 << ECHO_SHIFT) + PORT_SPACE - 1) / PORT_SPACE;
   localparam int              PROD_W     = ECHO_SHIFT + ECHO_QW;

   logic [PORT_W-1:0]  port;
   logic [BYTE_W-1:0]  data;
   logic [BYTE_W-1:0]  kstat;
   logic [PROD_W-1:0]  quot_prod;
   port_class_type     pclass;

   assign port  = req_tdata[PORT_W-1:0];
   assign data  = req_tdata[PORT_W +: BYTE_W];
   assign kstat = req_tdata[PORT_W + BYTE_W +: BYTE_W];

   always_comb begin
      unique case (port)
         PORT_PIC_CMD:    pclass = PCL_EOI;
         PORT_KBD_DATA:   pclass = PCL_KEY_DATA;
         PORT_KBD_STAT:   pclass = PCL_KEY_STAT;
         PORT_DAC_INDEX:  pclass = PCL_DAC_INDEX;
         PORT_DAC_DATA:   pclass = PCL_DAC_DATA;
         PORT_CRTC_INDEX: pclass = PCL_CRTC_INDEX;
         PORT_CRTC_DATA:  pclass = PCL_CRTC_DATA;
         PORT_MODE:       pclass = PCL_MODE;
         default:         pclass = PCL_OTHER;
      endcase
   end

   assign quot_prod = PROD_W'(port) * PROD_W'(ECHO_RECIP);

   assign req_tready = !q_full && !clearing;
   assign q_push     = req_tvalid && req_tready;

   assign q_item = '{
      action: action_type'(req_tuser[ACTION_W-1:0]),
      pclass: pclass,
      port:   port,
      echo_q: quot_prod[ECHO_SHIFT +: ECHO_QW],
      data:   data,
      kstat:  kstat
   };

endmodule

// ----- rtl/core/pcdk_queue.sv -----
// Short item queue between the front end and the execution back end.
module pcdk_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pcdk_pkg::item_type push_item,
   input  logic               pop,
   output pcdk_pkg::item_type head,
   output logic               q_valid,
   output logic               q_full
);
   import pcdk_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + CNT_W'(1);
            2'b01:   count_ff <= count_ff - CNT_W'(1);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head    = entry_ff[rd_ptr_ff];
   assign q_valid = (count_ff != '0);
   assign q_full  = (count_ff == CNT_W'(QUEUE_DEPTH));

endmodule

// ----- rtl/core/pcdk_back.sv -----
// Back end: executes port, key and palette items, owns the echo store and palette RAMs.
module pcdk_back #(
   parameter int PORT_SPACE   = pcdk_pkg::PORT_SPACE_DEF,
   parameter int TEXT_COLUMNS = pcdk_pkg::TEXT_COLUMNS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_valid,
   input  pcdk_pkg::item_type               q_head,
   output logic                             q_pop,
   output logic                             clearing,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // read_data[7:0], cursor_col[14:8], cursor_row[19:15], cursor_start_line[25:20],
   // cursor_end_line[30:26], video_mode[32:31], eoi_clear[33], palette_index[41:34],
   // palette_color[65:42], zero fill above
   output logic [pcdk_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [pcdk_pkg::RSP_TUSER_W-1:0] rsp_tuser   // palette_written[0]
);
   import pcdk_pkg::*;

   localparam int ECHO_AW    = $clog2(PORT_SPACE);
   localparam int LIN_W      = PORT_W + 1;
   // row = pos / TEXT_COLUMNS by reciprocal multiply, exact for any 11-bit pos
   localparam int COL_SHIFT  = POS_W + $clog2(TEXT_COLUMNS);
   localparam int COL_RECIP  = ((1 << COL_SHIFT) + TEXT_COLUMNS - 1) / TEXT_COLUMNS;
   localparam int ROW_FULL_W = $clog2(((1 << POS_W) - 1) / TEXT_COLUMNS + 1);
   localparam int ROWP_W     = COL_SHIFT + ROW_FULL_W;
   localparam int PAD_W      = RSP_TDATA_W - (2 * BYTE_W + COL_W + ROW_W + START_W + END_W
                                              + MODE_W + 1 + COLOR_W);

   typedef enum logic [1:0] {
      PH_RED,
      PH_GREEN,
      PH_BLUE
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0]     rd;
      logic [POS_W-1:0]      pos;
      logic [ROW_FULL_W-1:0] row_full;
      logic [COL_W-1:0]      col;
      logic [START_W-1:0]    start_line;
      logic [END_W-1:0]      end_line;
      logic [MODE_W-1:0]     mode;
      logic                  eoi;
      logic                  pw;
      logic [BYTE_W-1:0]     pidx;
      logic [COLOR_W-1:0]    pcol;
   } res_type;

   // pipeline control
   logic adv;

   // echo store clearing pass
   logic               clr_busy_ff;
   logic [ECHO_AW-1:0] clr_addr_ff;

   // issue
   logic [LIN_W-1:0]   echo_lin;
   logic [ECHO_AW-1:0] issue_addr;

   // execute stage
   logic               ex_vld_ff;
   item_type           ex_item_ff;
   logic [ECHO_AW-1:0] ex_addr_ff;
   logic               echo_hit_ff,  echo_hit_in;
   logic [BYTE_W-1:0]  echo_fwd_ff;
   logic               pal_hit_ff,   pal_hit_in;
   logic [COLOR_W-1:0] pal_fwd_ff;
   logic               pal_ent_vld_ff;
   logic [PALETTE_DEPTH-1:0] pal_valid_ff;

   logic [BYTE_W-1:0]  echo_rdata;
   logic [COLOR_W-1:0] pal_rdata;
   logic [BYTE_W-1:0]  echo_val;
   logic [COLOR_W-1:0] pal_val;
   logic               echo_wr;
   logic               echo_we;
   logic [ECHO_AW-1:0] echo_waddr;
   logic [BYTE_W-1:0]  echo_wdata;
   logic               pal_we;

   // architectural state
   logic [PAL_AW-1:0]  ptr_ff,       ptr_in;
   phase_type          phase_ff,     phase_in;
   logic [COLOR_W-1:0] color_ff,     color_in;
   logic [BYTE_W-1:0]  crtc_idx_ff,  crtc_idx_in;
   logic [START_W-1:0] cur_start_ff, cur_start_in;
   logic [END_W-1:0]   cur_end_ff,   cur_end_in;
   logic [HIGH_W-1:0]  cur_high_ff,  cur_high_in;
   logic [BYTE_W-1:0]  cur_low_ff,   cur_low_in;
   logic [MODE_W-1:0]  mode_ff,      mode_in;
   logic [BYTE_W-1:0]  key_data_ff,  key_data_in;
   logic [BYTE_W-1:0]  key_stat_ff,  key_stat_in;

   logic [BYTE_W-1:0]  rd;
   logic               eoi;
   logic               pw;
   logic [BYTE_W-1:0]  pidx;
   logic [COLOR_W-1:0] pcol;
   logic [CHAN_W-1:0]  six;

   // result tail
   logic               d_vld_ff, m_vld_ff, out_vld_ff;
   res_type            ex_res, d_res_ff, m_res, m_res_ff, o_res, o_res_ff;
   logic [ROWP_W-1:0]  row_prod;
   logic [POS_W-1:0]   col_lin;

   assign adv      = !out_vld_ff || rsp_tready;
   assign q_pop    = adv && q_valid;
   assign clearing = clr_busy_ff;

   // -------------------------------------------------------------- clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + ECHO_AW'(1);
         if (clr_addr_ff == ECHO_AW'(PORT_SPACE - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------- issue
   assign echo_lin   = LIN_W'(q_head.port) - LIN_W'(q_head.echo_q) * LIN_W'(PORT_SPACE);
   assign issue_addr = echo_lin[ECHO_AW-1:0];

   // writes by the item leaving execute land in the same cycle the next read issues
   assign echo_hit_in = echo_wr && (ex_addr_ff == issue_addr);
   assign pal_hit_in  = pw && (ptr_ff == q_head.data);

   assign echo_wr    = ex_vld_ff && (ex_item_ff.action == ACT_WRITE);
   assign echo_we    = clr_busy_ff || (adv && echo_wr);
   assign echo_waddr = clr_busy_ff ? clr_addr_ff : ex_addr_ff;
   assign echo_wdata = clr_busy_ff ? '0 : ex_item_ff.data;
   assign pal_we     = adv && pw;

   pcdk_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (PORT_SPACE)
   ) u_echo_ram (
      .clock   (clock),
      .wr_en   (echo_we),
      .wr_addr (echo_waddr),
      .wr_data (echo_wdata),
      .rd_en   (adv),
      .rd_addr (issue_addr),
      .rd_data (echo_rdata)
   );

   pcdk_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (PALETTE_DEPTH)
   ) u_pal_ram (
      .clock   (clock),
      .wr_en   (pal_we),
      .wr_addr (ptr_ff),
      .wr_data (color_in),
      .rd_en   (adv),
      .rd_addr (q_head.data),
      .rd_data (pal_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pal_valid_ff <= '0;
      end else if (pal_we) begin
         pal_valid_ff[ptr_ff] <= 1'b1;
      end
   end

   // -------------------------------------------------------------- execute
   assign echo_val = echo_hit_ff ? echo_fwd_ff : echo_rdata;
   assign pal_val  = pal_hit_ff ? pal_fwd_ff : (pal_ent_vld_ff ? pal_rdata : '0);
   assign six      = ex_item_ff.data[CHAN_W-1:0];

   always_comb begin
      ptr_in       = ptr_ff;
      phase_in     = phase_ff;
      color_in     = color_ff;
      crtc_idx_in  = crtc_idx_ff;
      cur_start_in = cur_start_ff;
      cur_end_in   = cur_end_ff;
      cur_high_in  = cur_high_ff;
      cur_low_in   = cur_low_ff;
      mode_in      = mode_ff;
      key_data_in  = key_data_ff;
      key_stat_in  = key_stat_ff;
      rd           = '0;
      eoi          = 1'b0;
      pw           = 1'b0;
      pidx         = '0;
      pcol         = '0;
      if (ex_vld_ff) begin
         unique case (ex_item_ff.action)
            ACT_READ: begin
               rd = echo_val;
               unique case (ex_item_ff.pclass)
                  PCL_KEY_DATA: rd = key_data_ff;
                  PCL_KEY_STAT: begin
                     rd          = key_stat_ff;
                     key_stat_in = {key_stat_ff[BYTE_W-1:1], 1'b0};
                  end
                  PCL_CRTC_INDEX: rd = crtc_idx_ff;
                  PCL_CRTC_DATA: begin
                     unique case (crtc_idx_ff)
                        CRTC_CUR_START: rd = BYTE_W'(cur_start_ff);
                        CRTC_CUR_END:   rd = BYTE_W'(cur_end_ff);
                        CRTC_CUR_HIGH:  rd = BYTE_W'(cur_high_ff);
                        CRTC_CUR_LOW:   rd = cur_low_ff;
                        default:        ;
                     endcase
                  end
                  default: ;
               endcase
            end
            ACT_WRITE: begin
               unique case (ex_item_ff.pclass)
                  PCL_EOI: eoi = ex_item_ff.data[EOI_BIT];
                  PCL_DAC_INDEX: begin
                     ptr_in   = ex_item_ff.data;
                     phase_in = PH_RED;
                     color_in = '0;
                  end
                  PCL_DAC_DATA: begin
                     // three component writes build one entry, then advance the pointer
                     unique case (phase_ff)
                        PH_RED: begin
                           phase_in = PH_GREEN;
                           color_in = {six, 2'b00, color_ff[15:0]};
                        end
                        PH_GREEN: begin
                           phase_in = PH_BLUE;
                           color_in = {color_ff[23:16], six, 2'b00, color_ff[7:0]};
                        end
                        PH_BLUE: begin
                           phase_in = PH_RED;
                           color_in = {color_ff[23:8], six, 2'b00};
                           pw       = 1'b1;
                           pidx     = ptr_ff;
                           pcol     = color_in;
                           ptr_in   = ptr_ff + PAL_AW'(1);
                        end
                        default: ;
                     endcase
                  end
                  PCL_CRTC_INDEX: crtc_idx_in = ex_item_ff.data;
                  PCL_CRTC_DATA: begin
                     unique case (crtc_idx_ff)
                        CRTC_CUR_START: cur_start_in = ex_item_ff.data[START_W-1:0];
                        CRTC_CUR_END:   cur_end_in   = ex_item_ff.data[END_W-1:0];
                        CRTC_CUR_HIGH:  cur_high_in  = ex_item_ff.data[HIGH_W-1:0];
                        CRTC_CUR_LOW:   cur_low_in   = ex_item_ff.data;
                        default:        ;
                     endcase
                  end
                  PCL_MODE: mode_in = ex_item_ff.data[MODE_W-1:0];
                  default: ;
               endcase
            end
            ACT_KEY: begin
               key_data_in = ex_item_ff.data;
               key_stat_in = ex_item_ff.kstat;
            end
            ACT_LOOKUP: begin
               pidx = ex_item_ff.data;
               pcol = pal_val;
            end
            default: ;
         endcase
      end
   end

   assign ex_res = '{
      rd:         rd,
      pos:        {cur_high_in, cur_low_in},
      row_full:   '0,
      col:        '0,
      start_line: cur_start_in,
      end_line:   cur_end_in,
      mode:       mode_in,
      eoi:        eoi,
      pw:         pw,
      pidx:       pidx,
      pcol:       pcol
   };

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         phase_ff     <= PH_RED;
         color_ff     <= '0;
         crtc_idx_ff  <= '0;
         cur_start_ff <= CUR_START_RST;
         cur_end_ff   <= CUR_END_RST;
         cur_high_ff  <= '0;
         cur_low_ff   <= '0;
         mode_ff      <= '0;
         key_data_ff  <= '0;
         key_stat_ff  <= '0;
         ex_vld_ff    <= 1'b0;
         d_vld_ff     <= 1'b0;
         m_vld_ff     <= 1'b0;
         out_vld_ff   <= 1'b0;
      end else if (adv) begin
         ptr_ff       <= ptr_in;
         phase_ff     <= phase_in;
         color_ff     <= color_in;
         crtc_idx_ff  <= crtc_idx_in;
         cur_start_ff <= cur_start_in;
         cur_end_ff   <= cur_end_in;
         cur_high_ff  <= cur_high_in;
         cur_low_ff   <= cur_low_in;
         mode_ff      <= mode_in;
         key_data_ff  <= key_data_in;
         key_stat_ff  <= key_stat_in;
         ex_vld_ff    <= q_valid;
         d_vld_ff     <= ex_vld_ff;
         m_vld_ff     <= d_vld_ff;
         out_vld_ff   <= m_vld_ff;
      end
   end

   // -------------------------------------------------------------- cursor tail
   assign row_prod = ROWP_W'(d_res_ff.pos) * ROWP_W'(COL_RECIP);

   always_comb begin
      m_res          = d_res_ff;
      m_res.row_full = row_prod[COL_SHIFT +: ROW_FULL_W];
   end

   assign col_lin = m_res_ff.pos
                    - POS_W'(POS_W'(m_res_ff.row_full) * POS_W'(TEXT_COLUMNS));

   always_comb begin
      o_res     = m_res_ff;
      o_res.col = col_lin[COL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ex_item_ff     <= q_head;
         ex_addr_ff     <= issue_addr;
         echo_hit_ff    <= echo_hit_in;
         echo_fwd_ff    <= ex_item_ff.data;
         pal_hit_ff     <= pal_hit_in;
         pal_fwd_ff     <= color_in;
         pal_ent_vld_ff <= pal_valid_ff[q_head.data];
         d_res_ff       <= ex_res;
         m_res_ff       <= m_res;
         o_res_ff       <= o_res;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {PAD_W'(0), o_res_ff.pcol, o_res_ff.pidx, o_res_ff.eoi, o_res_ff.mode,
                        o_res_ff.end_line, o_res_ff.start_line,
                        o_res_ff.row_full[ROW_W-1:0], o_res_ff.col, o_res_ff.rd};
   assign rsp_tuser  = o_res_ff.pw;

endmodule

// ----- rtl/core/pc_display_keyboard_io_ports.sv -----
// Top level of the display and keyboard I/O port block.
//
// Request channel (req_): one item per handshake; tuser carries the action
// (port read, port write, key event, palette lookup), tdata the port, data
// byte and key status byte. Result channel (rsp_): exactly one item for each
// request, in order: read byte, cursor column and row, cursor shape, video
// mode, EOI strobe, and the palette entry written or looked up; tuser flags
// a completed palette write.
// Throughput: one item per cycle while the receiver keeps rsp_tready high.
// From acceptance to rsp_tvalid, with the internal queue empty, an item passes
// the 2-entry queue, whose pop also issues the RAM reads, the execute stage
// and two cursor divide stages.
// Reset: the echo store, PORT_SPACE entries (65536 by default), is swept to
// zero, one entry per cycle; req_tready stays low until the sweep ends.
// Palette entries read as zero until written.
// Receiver stall: the result register holds, the back end freezes, and the
// queue keeps accepting until full, then req_tready drops.
module pc_display_keyboard_io_ports #(
   parameter int PORT_SPACE   = pcdk_pkg::PORT_SPACE_DEF,
   parameter int TEXT_COLUMNS = pcdk_pkg::TEXT_COLUMNS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [pcdk_pkg::REQ_TDATA_W-1:0] req_tdata,  // port[15:0], data[23:16], key_status[31:24]
   input  logic [pcdk_pkg::REQ_TUSER_W-1:0] req_tuser,  // action[1:0]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // read_data[7:0], cursor_col[14:8], cursor_row[19:15], cursor_start_line[25:20],
   // cursor_end_line[30:26], video_mode[32:31], eoi_clear[33], palette_index[41:34],
   // palette_color[65:42], zero fill above
   output logic [pcdk_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [pcdk_pkg::RSP_TUSER_W-1:0] rsp_tuser   // palette_written[0]
);
   import pcdk_pkg::*;

   logic     clearing;
   logic     q_full;
   logic     q_push;
   logic     q_pop;
   logic     q_valid;
   item_type q_item;
   item_type q_head;

   pcdk_front #(
      .PORT_SPACE (PORT_SPACE)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .clearing   (clearing),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (q_item)
   );

   pcdk_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .pop       (q_pop),
      .head      (q_head),
      .q_valid   (q_valid),
      .q_full    (q_full)
   );

   pcdk_back #(
      .PORT_SPACE   (PORT_SPACE),
      .TEXT_COLUMNS (TEXT_COLUMNS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef SYNTHESIS
   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_tready)
      else $error("item accepted during echo store clearing");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push)
      else $error("queue overflow");

   a_no_result_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !rsp_tvalid && !q_valid)
      else $error("result or queued item during echo store clearing");
`endif

endmodule

// ----- tb/pc_display_keyboard_io_ports_tb.sv -----
// Self-checking testbench for the display and keyboard I/O port block.
`timescale 1ns / 100ps

module pc_display_keyboard_io_ports_tb;
   import pcdk_pkg::*;

   localparam int ITEM_TARGET    = 1800;
   localparam int TAIL_ITEMS     = 200;
   localparam int DRAIN_CYCLES   = 16;
   // nothing is accepted during the echo store sweep after reset
   localparam int WATCHDOG_LIMIT = 3 * PORT_SPACE_DEF;

   localparam logic [PORT_W-1:0] NAMED_PORTS [12] = '{
      PORT_PIC_CMD, PORT_KBD_DATA, PORT_KBD_STAT, PORT_DAC_INDEX, PORT_DAC_DATA,
      PORT_CRTC_INDEX, PORT_CRTC_DATA, PORT_MODE, 16'h00FE, 16'h00FF, 16'h0000, 16'hFFFF
   };
   localparam logic [BYTE_W-1:0] CURSOR_REGS [4] = '{
      CRTC_CUR_START, CRTC_CUR_END, CRTC_CUR_HIGH, CRTC_CUR_LOW
   };

   typedef struct packed {
      logic [BYTE_W-1:0]  read_data;
      logic [COL_W-1:0]   cursor_col;
      logic [ROW_W-1:0]   cursor_row;
      logic [START_W-1:0] start_line;
      logic [END_W-1:0]   end_line;
      logic [MODE_W-1:0]  video_mode;
      logic               eoi_clear;
      logic               palette_written;
      logic [BYTE_W-1:0]  palette_index;
      logic [COLOR_W-1:0] palette_color;
   } port_response_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;

   // shadow copy of the port block state
   logic [BYTE_W-1:0]  echo_mem [PORT_RANGE];
   logic [COLOR_W-1:0] pal_mem [PALETTE_DEPTH];
   logic [BYTE_W-1:0]  dac_ptr = '0;
   int                 dac_phase = 0;
   logic [COLOR_W-1:0] dac_color = '0;
   logic [BYTE_W-1:0]  crtc_idx = '0;
   logic [START_W-1:0] cur_start = CUR_START_RST;
   logic [END_W-1:0]   cur_end = CUR_END_RST;
   logic [HIGH_W-1:0]  cur_high = '0;
   logic [BYTE_W-1:0]  cur_low = '0;
   logic [MODE_W-1:0]  mode_bits = '0;
   logic [BYTE_W-1:0]  kbd_data = '0;
   logic [BYTE_W-1:0]  kbd_status = '0;

   port_response_type expected_responses [$];
   int                mismatch_count = 0;
   int                items_sent = 0;
   int                idle_odds = 4;
   int                rx_stall_left = 0;
   int                stuck_cycles = 0;

   pc_display_keyboard_io_ports u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   initial begin
      for (int i = 0; i < PORT_RANGE; i++) echo_mem[i] = '0;
      for (int i = 0; i < PALETTE_DEPTH; i++) pal_mem[i] = '0;
   end

   // Work out the response to one access and advance the shadow state.
   function automatic port_response_type predict_port_response(action_type act,
         logic [PORT_W-1:0] port, logic [BYTE_W-1:0] data, logic [BYTE_W-1:0] kstat);
      port_response_type  r;
      logic [POS_W-1:0]   pos;
      r = '0;
      case (act)
         ACT_READ: begin
            if (port == PORT_KBD_DATA) begin
               r.read_data = kbd_data;
            end else if (port == PORT_KBD_STAT) begin
               r.read_data = kbd_status;
               kbd_status[0] = 1'b0;
            end else if (port == PORT_CRTC_INDEX) begin
               r.read_data = crtc_idx;
            end else if (port == PORT_CRTC_DATA && crtc_idx == CRTC_CUR_START) begin
               r.read_data = BYTE_W'(cur_start);
            end else if (port == PORT_CRTC_DATA && crtc_idx == CRTC_CUR_END) begin
               r.read_data = BYTE_W'(cur_end);
            end else if (port == PORT_CRTC_DATA && crtc_idx == CRTC_CUR_HIGH) begin
               r.read_data = BYTE_W'(cur_high);
            end else if (port == PORT_CRTC_DATA && crtc_idx == CRTC_CUR_LOW) begin
               r.read_data = cur_low;
            end else begin
               r.read_data = echo_mem[port];
            end
         end
         ACT_WRITE: begin
            if (port == PORT_PIC_CMD) begin
               r.eoi_clear = data[EOI_BIT];
            end else if (port == PORT_DAC_INDEX) begin
               dac_ptr = data;
               dac_phase = 0;
               dac_color = '0;
            end else if (port == PORT_DAC_DATA) begin
               case (dac_phase)
                  0: begin
                     dac_color[23:18] = data[CHAN_W-1:0];
                     dac_phase = 1;
                  end
                  1: begin
                     dac_color[15:10] = data[CHAN_W-1:0];
                     dac_phase = 2;
                  end
                  default: begin
                     dac_color[7:2] = data[CHAN_W-1:0];
                     pal_mem[dac_ptr] = dac_color;
                     r.palette_written = 1'b1;
                     r.palette_index = dac_ptr;
                     r.palette_color = dac_color;
                     dac_ptr = dac_ptr + 1'b1;
                     dac_phase = 0;
                  end
               endcase
            end else if (port == PORT_CRTC_INDEX) begin
               crtc_idx = data;
            end else if (port == PORT_CRTC_DATA) begin
               if (crtc_idx == CRTC_CUR_START) cur_start = data[START_W-1:0];
               else if (crtc_idx == CRTC_CUR_END) cur_end = data[END_W-1:0];
               else if (crtc_idx == CRTC_CUR_HIGH) cur_high = data[HIGH_W-1:0];
               else if (crtc_idx == CRTC_CUR_LOW) cur_low = data;
            end else if (port == PORT_MODE) begin
               mode_bits = data[MODE_W-1:0];
            end
            echo_mem[port] = data;
         end
         ACT_KEY: begin
            kbd_data = data;
            kbd_status = kstat;
         end
         default: begin
            r.palette_index = data;
            r.palette_color = pal_mem[data];
         end
      endcase
      pos = {cur_high, cur_low};
      r.cursor_col = COL_W'(pos % TEXT_COLUMNS_DEF);
      r.cursor_row = ROW_W'(pos / TEXT_COLUMNS_DEF);
      r.start_line = cur_start;
      r.end_line = cur_end;
      r.video_mode = mode_bits;
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
         mismatch_count++;
      end
   endfunction

   function automatic logic [PORT_W-1:0] pick_port();
      case ($urandom_range(0, 3))
         0: return NAMED_PORTS[$urandom_range(0, 11)];
         1: return PORT_W'($urandom_range(0, 16'h03FF));
         default: return PORT_W'($urandom());
      endcase
   endfunction

   // Compare each returned item with the oldest expectation.
   always @(posedge clock) begin
      port_response_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_responses.size() == 0) begin
            $error("unexpected response item: tdata 0x%0h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = expected_responses.pop_front();
            check_field("read_data", want.read_data, rsp_tdata[7:0]);
            check_field("cursor_col", want.cursor_col, rsp_tdata[14:8]);
            check_field("cursor_row", want.cursor_row, rsp_tdata[19:15]);
            check_field("cursor_start_line", want.start_line, rsp_tdata[25:20]);
            check_field("cursor_end_line", want.end_line, rsp_tdata[30:26]);
            check_field("video_mode", want.video_mode, rsp_tdata[32:31]);
            check_field("eoi_clear", want.eoi_clear, rsp_tdata[33]);
            check_field("palette_index", want.palette_index, rsp_tdata[41:34]);
            check_field("palette_color", want.palette_color, rsp_tdata[65:42]);
            check_field("tdata_fill", '0, rsp_tdata[71:66]);
            check_field("palette_written", want.palette_written, rsp_tuser[0]);
         end
      end
   end

   // Stall the result side at random, holding rsp_tready low in bursts.
   always @(posedge clock) begin
      if (rx_stall_left > 0) begin
         rsp_tready <= 1'b0;
         rx_stall_left <= rx_stall_left - 1;
      end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
         rsp_tready <= 1'b0;
         rx_stall_left <= $urandom_range(0, 14);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("pc_display_keyboard_io_ports_tb: FAIL");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   task automatic send_port_item(action_type act, logic [PORT_W-1:0] port,
         logic [BYTE_W-1:0] data, logic [BYTE_W-1:0] kstat);
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {kstat, data, port};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_responses.push_back(predict_port_response(act, port, data, kstat));
      items_sent++;
      if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task automatic wait_for_all_responses();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_responses.size() != 0);
   endtask

   task automatic test_reset_state();
      send_port_item(ACT_READ, PORT_CRTC_INDEX, 8'h00, 8'h00);
      // index 0 is no cursor register: data port falls back to its echo
      send_port_item(ACT_READ, PORT_CRTC_DATA, 8'h00, 8'h00);
      send_port_item(ACT_READ, 16'hFFFF, 8'h00, 8'h00);
      send_port_item(ACT_LOOKUP, 16'h0000, 8'h00, 8'h00);
   endtask

   task automatic test_crtc_cursor();
      foreach (CURSOR_REGS[i]) begin
         send_port_item(ACT_WRITE, PORT_CRTC_INDEX, CURSOR_REGS[i], 8'h00);
         send_port_item(ACT_WRITE, PORT_CRTC_DATA, 8'hFF, 8'h00);
      end
      send_port_item(ACT_READ, PORT_CRTC_DATA, 8'h00, 8'h00);
      // unknown index: data write lands only in the echo store
      send_port_item(ACT_WRITE, PORT_CRTC_INDEX, 8'h55, 8'h00);
      send_port_item(ACT_WRITE, PORT_CRTC_DATA, 8'hA5, 8'h00);
      send_port_item(ACT_READ, PORT_CRTC_DATA, 8'h00, 8'h00);
   endtask

   task automatic test_dac_palette();
      send_port_item(ACT_WRITE, PORT_DAC_INDEX, 8'hFF, 8'h00);
      send_port_item(ACT_WRITE, PORT_DAC_DATA, 8'h3F, 8'h00);
      send_port_item(ACT_WRITE, PORT_DAC_DATA, 8'h00, 8'h00);
      // pointer wraps to zero after this entry
      send_port_item(ACT_WRITE, PORT_DAC_DATA, 8'hFF, 8'h00);
      send_port_item(ACT_WRITE, PORT_DAC_DATA, 8'hEA, 8'h00);
      send_port_item(ACT_LOOKUP, 16'hFFFF, 8'hFF, 8'h00);
   endtask

   task automatic test_keyboard_eoi_mode();
      send_port_item(ACT_KEY, 16'hFFFF, 8'hFF, 8'hFF);
      send_port_item(ACT_READ, PORT_KBD_DATA, 8'h00, 8'h00);
      send_port_item(ACT_READ, PORT_KBD_STAT, 8'h00, 8'h00);
      send_port_item(ACT_READ, PORT_KBD_STAT, 8'h00, 8'h00);
      send_port_item(ACT_WRITE, PORT_PIC_CMD, 8'h20, 8'h00);
      send_port_item(ACT_WRITE, PORT_PIC_CMD, 8'hDF, 8'h00);
      send_port_item(ACT_WRITE, PORT_MODE, 8'hFF, 8'h00);
   endtask

   task automatic test_random_traffic();
      logic [PORT_W-1:0] port;
      logic [BYTE_W-1:0] pick;
      bit                drained = 1'b0;
      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= ITEM_TARGET - TAIL_ITEMS) begin
            idle_odds = 0;
         end else if ($urandom_range(0, 29) == 0) begin
            case ($urandom_range(0, 2))
               0: idle_odds = 0;
               1: idle_odds = 3;
               default: idle_odds = 10;
            endcase
         end
         if (!drained && items_sent >= ITEM_TARGET / 2) begin
            wait_for_all_responses();
            drained = 1'b1;
         end
         case ($urandom_range(0, 99)) inside
            [0:19]: begin
               if ($urandom_range(0, 4) != 0)
                  send_port_item(ACT_WRITE, PORT_DAC_INDEX, 8'($urandom()), 8'($urandom()));
               repeat ($urandom_range(0, 7) == 0 ? $urandom_range(1, 2) : 3)
                  send_port_item(ACT_WRITE, PORT_DAC_DATA, 8'($urandom()), 8'($urandom()));
               send_port_item(ACT_LOOKUP, pick_port(),
                              $urandom_range(0, 1) ? dac_ptr - 1'b1 : 8'($urandom()),
                              8'($urandom()));
            end
            [20:39]: begin
               pick = $urandom_range(0, 4) == 0 ? 8'($urandom())
                                                : CURSOR_REGS[$urandom_range(0, 3)];
               send_port_item(ACT_WRITE, PORT_CRTC_INDEX, pick, 8'($urandom()));
               if ($urandom_range(0, 3) != 0)
                  send_port_item(ACT_WRITE, PORT_CRTC_DATA, 8'($urandom()), 8'($urandom()));
               send_port_item(ACT_READ, PORT_CRTC_DATA, 8'($urandom()), 8'($urandom()));
               if ($urandom_range(0, 1)) send_port_item(ACT_READ, PORT_CRTC_INDEX, 8'h00, 8'h00);
            end
            [40:49]: begin
               send_port_item(ACT_KEY, PORT_W'($urandom()), 8'($urandom()), 8'($urandom()));
               send_port_item(ACT_READ, PORT_KBD_DATA, 8'($urandom()), 8'($urandom()));
               repeat ($urandom_range(1, 2))
                  send_port_item(ACT_READ, PORT_KBD_STAT, 8'($urandom()), 8'($urandom()));
            end
            [50:57]: begin
               send_port_item(ACT_WRITE, PORT_PIC_CMD, 8'($urandom()), 8'($urandom()));
               send_port_item(ACT_WRITE, PORT_MODE, 8'($urandom()), 8'($urandom()));
               send_port_item(ACT_READ, PORT_MODE, 8'($urandom()), 8'($urandom()));
            end
            [58:74]: begin
               port = pick_port();
               send_port_item(ACT_WRITE, port, 8'($urandom()), 8'($urandom()));
               send_port_item(ACT_READ, port, 8'($urandom()), 8'($urandom()));
            end
            [75:84]: begin
               send_port_item(ACT_LOOKUP, PORT_W'($urandom()), 8'($urandom()), 8'($urandom()));
            end
            default: begin
               send_port_item(action_type'($urandom_range(0, 3)), pick_port(),
                              8'($urandom()), 8'($urandom()));
            end
         endcase
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_crtc_cursor();
      test_dac_palette();
      wait_for_all_responses();
      test_keyboard_eoi_mode();
      test_random_traffic();
      wait_for_all_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_responses.size() == 0) begin
         $display("pc_display_keyboard_io_ports_tb: PASS");
      end else begin
         $display("pc_display_keyboard_io_ports_tb: FAIL");
      end
      $finish;
   end

endmodule
